FILE: sv/rtcf_pkg.sv
// ----------------------------------------------------------------------------
// rtcf_pkg
// Shared types and constants for the rigid transform crop filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtcf_pkg;

  // Upper bound on points counted per scan
  localparam logic [31:0] MAX_SCAN_POINTS = 32'd1048575;

  localparam int CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_ALL_ONES = {CNT_W{1'b1}};

  // Effective saturation value of the per-scan counters
  localparam logic [CNT_W-1:0] CNT_CAP =
    (MAX_SCAN_POINTS < {12'd0, CNT_ALL_ONES}) ? MAX_SCAN_POINTS[CNT_W-1:0] : CNT_ALL_ONES;

  localparam int COORD_W = 32;
  localparam int ROW_W   = 48;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = COEF_W + COORD_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int FRAC_SH = 14;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  // Register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_ROT_ROW_X    = 3'd0,
    REG_ROT_ROW_Y    = 3'd1,
    REG_OFFSET_X     = 3'd2,
    REG_OFFSET_Y     = 3'd3,
    REG_LEGAL_X_LOW  = 3'd4,
    REG_LEGAL_X_HIGH = 3'd5,
    REG_LEGAL_Y_LOW  = 3'd6,
    REG_LEGAL_Y_HIGH = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [ROW_W-1:0]   rot_row_x;
    logic        [ROW_W-1:0]   rot_row_y;
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic signed [COORD_W-1:0] legal_x_low;
    logic signed [COORD_W-1:0] legal_x_high;
    logic signed [COORD_W-1:0] legal_y_low;
    logic signed [COORD_W-1:0] legal_y_high;
  } cfg_t;

endpackage

FILE: sv/rtcf_regs.sv
// ----------------------------------------------------------------------------
// rtcf_regs
// APB register file holding the transform rows, offsets and legal box.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcf_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtcf_pkg::PADDR_W-1:0]  paddr,
  input  logic [rtcf_pkg::PDATA_W-1:0]  pwdata,
  output logic [rtcf_pkg::PDATA_W-1:0]  prdata,
  output rtcf_pkg::cfg_t                cfg
);

  logic             wr_en;
  rtcf_pkg::reg_idx_t reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = rtcf_pkg::reg_idx_t'(paddr[5:3]);

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_row_x    <= 48'd16384;
      cfg.rot_row_y    <= 48'd1073741824;
      cfg.offset_x     <= 32'sd0;
      cfg.offset_y     <= 32'sd0;
      cfg.legal_x_low  <= 32'sh8000_0000;
      cfg.legal_x_high <= 32'sh7FFF_FFFF;
      cfg.legal_y_low  <= 32'sh8000_0000;
      cfg.legal_y_high <= 32'sh7FFF_FFFF;
    end else if (wr_en) begin
      case (reg_idx)
        rtcf_pkg::REG_ROT_ROW_X:    cfg.rot_row_x    <= pwdata[47:0];
        rtcf_pkg::REG_ROT_ROW_Y:    cfg.rot_row_y    <= pwdata[47:0];
        rtcf_pkg::REG_OFFSET_X:     cfg.offset_x     <= pwdata[31:0];
        rtcf_pkg::REG_OFFSET_Y:     cfg.offset_y     <= pwdata[31:0];
        rtcf_pkg::REG_LEGAL_X_LOW:  cfg.legal_x_low  <= pwdata[31:0];
        rtcf_pkg::REG_LEGAL_X_HIGH: cfg.legal_x_high <= pwdata[31:0];
        rtcf_pkg::REG_LEGAL_Y_LOW:  cfg.legal_y_low  <= pwdata[31:0];
        rtcf_pkg::REG_LEGAL_Y_HIGH: cfg.legal_y_high <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero extended
  always_comb begin
    case (reg_idx)
      rtcf_pkg::REG_ROT_ROW_X:    prdata = {16'd0, cfg.rot_row_x};
      rtcf_pkg::REG_ROT_ROW_Y:    prdata = {16'd0, cfg.rot_row_y};
      rtcf_pkg::REG_OFFSET_X:     prdata = {32'd0, cfg.offset_x};
      rtcf_pkg::REG_OFFSET_Y:     prdata = {32'd0, cfg.offset_y};
      rtcf_pkg::REG_LEGAL_X_LOW:  prdata = {32'd0, cfg.legal_x_low};
      rtcf_pkg::REG_LEGAL_X_HIGH: prdata = {32'd0, cfg.legal_x_high};
      rtcf_pkg::REG_LEGAL_Y_LOW:  prdata = {32'd0, cfg.legal_y_low};
      rtcf_pkg::REG_LEGAL_Y_HIGH: prdata = {32'd0, cfg.legal_y_high};
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: sv/rtcf_axis_check.sv
// ----------------------------------------------------------------------------
// rtcf_axis_check
// One arena axis: registered coefficient products, then sum and box compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcf_axis_check (
  input  logic                                clk,
  input  logic                                load,
  input  logic        [rtcf_pkg::ROW_W-1:0]   row,
  input  logic signed [rtcf_pkg::COORD_W-1:0] off,
  input  logic signed [rtcf_pkg::COORD_W-1:0] lo,
  input  logic signed [rtcf_pkg::COORD_W-1:0] hi,
  input  logic signed [rtcf_pkg::COORD_W-1:0] x,
  input  logic signed [rtcf_pkg::COORD_W-1:0] y,
  input  logic signed [rtcf_pkg::COORD_W-1:0] z,
  output logic                                in_box
);

  logic signed [rtcf_pkg::COEF_W-1:0] c0, c1, c2;
  logic signed [rtcf_pkg::PROD_W-1:0] p0, p1, p2;
  logic signed [rtcf_pkg::ACC_W-1:0]  acc, off_s, lo_s, hi_s;

  assign c0 = row[15:0];
  assign c1 = row[31:16];
  assign c2 = row[47:32];

  // Hold the three products of the rotation row
  always_ff @(posedge clk) begin
    if (load) begin
      p0 <= c0 * x;
      p1 <= c1 * y;
      p2 <= c2 * z;
    end
  end

  // Scale offset and bounds to the Q.30 product grid
  assign off_s = {{5{off[31]}}, off, 14'd0};
  assign lo_s  = {{5{lo[31]}}, lo, 14'd0};
  assign hi_s  = {{5{hi[31]}}, hi, 14'd0};

  assign acc = {{3{p0[47]}}, p0} + {{3{p1[47]}}, p1} + {{3{p2[47]}}, p2} + off_s;

  assign in_box = (acc >= lo_s) && (acc <= hi_s);

endmodule

FILE: sv/rtcf_scan_count.sv
// ----------------------------------------------------------------------------
// rtcf_scan_count
// Saturating per-scan finite and kept counters, cleared after the last point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcf_scan_count (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             point_valid,
  input  logic                             keep,
  input  logic                             scan_last,
  output logic [rtcf_pkg::CNT_W-1:0]       finite_total,
  output logic [rtcf_pkg::CNT_W-1:0]       kept_total
);

  logic [rtcf_pkg::CNT_W-1:0] finite_counter, kept_counter;

  // Count this point, stopping at the cap
  assign finite_total = (point_valid && finite_counter < rtcf_pkg::CNT_CAP) ?
                        finite_counter + 1'b1 : finite_counter;
  assign kept_total   = (keep && kept_counter < rtcf_pkg::CNT_CAP) ?
                        kept_counter + 1'b1 : kept_counter;

  // Advance on each result; clear after the scan's last point
  always_ff @(posedge clk) begin
    if (rst) begin
      finite_counter <= '0;
      kept_counter   <= '0;
    end else if (advance) begin
      if (scan_last) begin
        finite_counter <= '0;
        kept_counter   <= '0;
      end else begin
        finite_counter <= finite_total;
        kept_counter   <= kept_total;
      end
    end
  end

`ifndef SYNTH
  a_kept_le_finite: assert property (@(posedge clk) disable iff (rst)
    kept_counter <= finite_counter)
    else $error("kept counter exceeds finite counter");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    finite_counter <= rtcf_pkg::CNT_CAP && kept_counter <= rtcf_pkg::CNT_CAP)
    else $error("counter above saturation cap");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    advance && scan_last |=> finite_counter == '0 && kept_counter == '0)
    else $error("counters not cleared after last point");
`endif

endmodule

FILE: sv/rigid_transform_crop_filter_core.sv
// ----------------------------------------------------------------------------
// rigid_transform_crop_filter_core: a request passes the input, product and result registers.
// Throughput one point per cycle while the sink does not stall the result register.
// Synchronous reset restores register defaults and clears counts and valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rigid_transform_crop_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rtcf_pkg::PADDR_W-1:0]        paddr,
  input  logic [rtcf_pkg::PDATA_W-1:0]        pwdata,
  output logic [rtcf_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // point requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rtcf_pkg::COORD_W-1:0] x_coord,
  input  logic signed [rtcf_pkg::COORD_W-1:0] y_coord,
  input  logic signed [rtcf_pkg::COORD_W-1:0] z_coord,
  input  logic                                point_valid,
  input  logic                                scan_last,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                keep,
  output logic signed [rtcf_pkg::COORD_W-1:0] x_out,
  output logic signed [rtcf_pkg::COORD_W-1:0] y_out,
  output logic signed [rtcf_pkg::COORD_W-1:0] z_out,
  output logic [rtcf_pkg::CNT_W-1:0]          finite_total,
  output logic [rtcf_pkg::CNT_W-1:0]          kept_total,
  output logic [rtcf_pkg::CNT_W-1:0]          rejected_total,
  output logic                                scan_done
);

  rtcf_pkg::cfg_t cfg;

  logic en1, en2, en3;
  logic v1, v2;
  logic signed [rtcf_pkg::COORD_W-1:0] x1, y1, z1, x2, y2, z2;
  logic pv1, pv2, last1, last2;
  logic ins_x, ins_y, keep2, advance;
  logic [rtcf_pkg::CNT_W-1:0] fin_cnt, kept_cnt;

  assign pready = 1'b1;

  rtcf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Stage enables: a stage loads when it is empty or the next one loads
  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      x1    <= x_coord;
      y1    <= y_coord;
      z1    <= z_coord;
      pv1   <= point_valid;
      last1 <= scan_last;
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      x2    <= x1;
      y2    <= y1;
      z2    <= z1;
      pv2   <= pv1;
      last2 <= last1;
    end
  end

  rtcf_axis_check u_axis_x (
    .clk    (clk),
    .load   (en2 && v1),
    .row    (cfg.rot_row_x),
    .off    (cfg.offset_x),
    .lo     (cfg.legal_x_low),
    .hi     (cfg.legal_x_high),
    .x      (x1),
    .y      (y1),
    .z      (z1),
    .in_box (ins_x)
  );

  rtcf_axis_check u_axis_y (
    .clk    (clk),
    .load   (en2 && v1),
    .row    (cfg.rot_row_y),
    .off    (cfg.offset_y),
    .lo     (cfg.legal_y_low),
    .hi     (cfg.legal_y_high),
    .x      (x1),
    .y      (y1),
    .z      (z1),
    .in_box (ins_y)
  );

  assign keep2   = pv2 && ins_x && ins_y;
  assign advance = en3 && v2;

  rtcf_scan_count u_count (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .point_valid  (pv2),
    .keep         (keep2),
    .scan_last    (last2),
    .finite_total (fin_cnt),
    .kept_total   (kept_cnt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      keep           <= keep2;
      x_out          <= x2;
      y_out          <= y2;
      z_out          <= z2;
      finite_total   <= fin_cnt;
      kept_total     <= kept_cnt;
      rejected_total <= fin_cnt - kept_cnt;
      scan_done      <= last2;
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams lidar points through the crop filter core under random source gaps
// and sink stalls. A directed table covers bound edges, the inverted box and
// extreme coefficients; random phases follow, each with a new register set
// written and read back over APB. Each result is checked against its table row or a
// predictor of the rigid transform, the box test and the per-scan counters.
// ----------------------------------------------------------------------------

module testbench;
  import rtcf_pkg::*;

  localparam int RANDOM_PHASES    = 8;
  localparam int POINTS_PER_PHASE = 210;
  localparam int STALL_LIMIT      = 4000;
  localparam int HOLD_AFTER       = 600;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 10;
  localparam int REPORT_MAX       = 10;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] ONE_M     = 32'h0001_0000;
  localparam logic [COEF_W-1:0]  COEF_P1   = 16'h4000;
  localparam logic [COEF_W-1:0]  COEF_M1   = 16'hC000;
  localparam logic [COEF_W-1:0]  COEF_MAX  = 16'h7FFF;
  localparam logic [COEF_W-1:0]  COEF_MIN  = 16'h8000;
  localparam longint Q14_ONE = longint'(1) << FRAC_SH;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               valid;
    logic               last;
  } point_t;

  typedef struct packed {
    logic               keep;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [CNT_W-1:0]   finite;
    logic [CNT_W-1:0]   kept;
    logic [CNT_W-1:0]   rejected;
    logic               done;
  } result_t;

  typedef struct packed {
    logic [1:0]       phase;
    point_t           pt;
    logic             typed;
    logic             keep;
    logic [CNT_W-1:0] finite;
    logic [CNT_W-1:0] kept;
  } point_row_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [COORD_W-1:0] x_coord, y_coord, z_coord;
  logic point_valid, scan_last;
  logic keep, scan_done;
  logic signed [COORD_W-1:0] x_out, y_out, z_out;
  logic [CNT_W-1:0] finite_total, kept_total, rejected_total;

  // Predictor state: register image and per-scan counters
  cfg_t             arena_cfg;
  logic [CNT_W-1:0] finite_cnt, kept_cnt;

  result_t     pending_results[$];
  point_row_t  dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned points_accepted = 0;
  int unsigned burst_left = 0;
  int unsigned pt_span = 32'd1 << 20;
  int unsigned quiet_cycles = 0;

  rigid_transform_crop_filter_core DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .x_coord        (x_coord),
    .y_coord        (y_coord),
    .z_coord        (z_coord),
    .point_valid    (point_valid),
    .scan_last      (scan_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keep           (keep),
    .x_out          (x_out),
    .y_out          (y_out),
    .z_out          (z_out),
    .finite_total   (finite_total),
    .kept_total     (kept_total),
    .rejected_total (rejected_total),
    .scan_done      (scan_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count a failure; print only the first few
  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      flag_error($sformatf("%s: expected %0h, got %0h", name, exp_val, act_val));
    end
  endtask

  // Exact Q.30 arena coordinate compared against the scaled inclusive bounds
  function automatic logic axis_inside(input logic [ROW_W-1:0] row,
                                       input logic signed [COORD_W-1:0] off,
                                       input logic signed [COORD_W-1:0] lo,
                                       input logic signed [COORD_W-1:0] hi,
                                       input point_t p);
    longint acc;
    acc = longint'($signed(row[15:0]))  * longint'($signed(p.x))
        + longint'($signed(row[31:16])) * longint'($signed(p.y))
        + longint'($signed(row[47:32])) * longint'($signed(p.z))
        + longint'(off) * Q14_ONE;
    return (acc >= longint'(lo) * Q14_ONE) && (acc <= longint'(hi) * Q14_ONE);
  endfunction

  // Advance the scan counters for one point and form its result
  task automatic predict_point(input point_t p, output result_t r);
    logic in_box;
    in_box = axis_inside(arena_cfg.rot_row_x, arena_cfg.offset_x,
                         arena_cfg.legal_x_low, arena_cfg.legal_x_high, p)
          && axis_inside(arena_cfg.rot_row_y, arena_cfg.offset_y,
                         arena_cfg.legal_y_low, arena_cfg.legal_y_high, p);
    r.keep = p.valid && in_box;
    if (p.valid) begin
      if (finite_cnt < CNT_CAP) finite_cnt = finite_cnt + 1'b1;
      if (r.keep && kept_cnt < CNT_CAP) kept_cnt = kept_cnt + 1'b1;
    end
    r.x        = p.x;
    r.y        = p.y;
    r.z        = p.z;
    r.finite   = finite_cnt;
    r.kept     = kept_cnt;
    r.rejected = finite_cnt - kept_cnt;
    r.done     = p.last;
    if (p.last) begin
      finite_cnt = '0;
      kept_cnt   = '0;
    end
  endtask

  function automatic logic [PDATA_W-1:0] reg_image(input cfg_t c, input reg_idx_t idx);
    case (idx)
      REG_ROT_ROW_X:    return {16'd0, c.rot_row_x};
      REG_ROT_ROW_Y:    return {16'd0, c.rot_row_y};
      REG_OFFSET_X:     return {32'd0, c.offset_x};
      REG_OFFSET_Y:     return {32'd0, c.offset_y};
      REG_LEGAL_X_LOW:  return {32'd0, c.legal_x_low};
      REG_LEGAL_X_HIGH: return {32'd0, c.legal_x_high};
      REG_LEGAL_Y_LOW:  return {32'd0, c.legal_y_low};
      default:          return {32'd0, c.legal_y_high};
    endcase
  endfunction

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_xfer(input logic wr, input reg_idx_t idx,
                          input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'd0};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Optionally write every register, read each back, and adopt the settings
  task automatic apply_cfg(input cfg_t c, input logic do_write);
    reg_idx_t           idx;
    logic [PDATA_W-1:0] rd, mask;
    idx = idx.first();
    repeat (idx.num()) begin
      if (do_write) apb_xfer(1'b1, idx, reg_image(c, idx), rd);
      apb_xfer(1'b0, idx, '0, rd);
      mask = (idx == REG_ROT_ROW_X || idx == REG_ROT_ROW_Y) ? 64'h0000_FFFF_FFFF_FFFF
                                                              : 64'h0000_0000_FFFF_FFFF;
      check_field($sformatf("readback %s", idx.name()), reg_image(c, idx) & mask,
                  rd & mask);
      idx = idx.next();
    end
    arena_cfg = c;
  endtask

  // Offer one point; bursts end in a random gap
  task automatic send_point(input point_t p, input logic use_typed,
                            input result_t typed_res);
    result_t     predicted;
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    x_coord     <= p.x;
    y_coord     <= p.y;
    z_coord     <= p.z;
    point_valid <= p.valid;
    scan_last   <= p.last;
    do @(posedge clk); while (!in_ready);
    predict_point(p, predicted);
    pending_results.push_back(use_typed ? typed_res : predicted);
    points_accepted++;
    burst_left--;
  endtask

  task automatic stop_points();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] ph, input logic [COORD_W-1:0] x,
                         input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                         input logic pv, input logic last, input logic typed,
                         input logic kp, input logic [CNT_W-1:0] fin,
                         input logic [CNT_W-1:0] kp_cnt);
    point_row_t row;
    row.phase    = ph;
    row.pt.x     = x;
    row.pt.y     = y;
    row.pt.z     = z;
    row.pt.valid = pv;
    row.pt.last  = last;
    row.typed    = typed;
    row.keep     = kp;
    row.finite   = fin;
    row.kept     = kp_cnt;
    dir_rows.push_back(row);
  endtask

  function automatic logic [COORD_W-1:0] signed_within(input int unsigned span);
    return 32'(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    return ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'(signed_within(16384));
  endfunction

  // Random register set; the first two random phases take the extremes
  task automatic rand_cfg(input int ph, output cfg_t c);
    int unsigned span;
    span = 32'd1 << $urandom_range(8, 30);
    pt_span = span;
    c.rot_row_x = {rand_coef(), rand_coef(), rand_coef()};
    c.rot_row_y = {rand_coef(), rand_coef(), rand_coef()};
    c.offset_x  = ($urandom_range(0, 4) == 0) ? $urandom : signed_within(span >> 1);
    c.offset_y  = ($urandom_range(0, 4) == 0) ? $urandom : signed_within(span >> 1);
    c.legal_x_high = $urandom_range(0, span);
    c.legal_y_high = $urandom_range(0, span);
    c.legal_x_low  = 32'd0 - $urandom_range(0, span);
    c.legal_y_low  = 32'd0 - $urandom_range(0, span);
    case ($urandom_range(0, 7))
      0: begin
        c.legal_x_low  = COORD_MIN;
        c.legal_x_high = COORD_MAX;
      end
      1: begin
        c.legal_y_low = c.legal_y_high + $urandom_range(1, span);
      end
      default: ;
    endcase
    if (ph == 0) begin
      c.rot_row_x    = '1;
      c.rot_row_y    = '1;
      c.offset_x     = COORD_MAX;
      c.offset_y     = COORD_MAX;
      c.legal_x_low  = COORD_MIN;
      c.legal_y_low  = COORD_MIN;
      c.legal_x_high = COORD_MAX;
      c.legal_y_high = COORD_MAX;
    end else if (ph == 1) begin
      c.rot_row_x    = {COEF_MIN, COEF_MIN, COEF_MIN};
      c.rot_row_y    = {COEF_MIN, COEF_MIN, COEF_MIN};
      c.offset_x     = COORD_MIN;
      c.offset_y     = COORD_MIN;
      c.legal_x_low  = COORD_MIN;
      c.legal_y_low  = COORD_MIN;
      c.legal_x_high = COORD_MAX;
      c.legal_y_high = COORD_MAX;
    end
  endtask

  task automatic rand_point(output point_t p);
    if ($urandom_range(0, 3) == 0) begin
      p.x = $urandom;
      p.y = $urandom;
      p.z = $urandom;
    end else begin
      p.x = signed_within(pt_span);
      p.y = signed_within(pt_span);
      p.z = signed_within(pt_span);
    end
    p.valid = ($urandom_range(0, 99) < 85);
    p.last  = ($urandom_range(0, 24) == 0);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing pending: x=%0h", x_out));
      end else begin
        want = pending_results.pop_front();
        check_field("keep", want.keep, keep);
        check_field("x_out", want.x, $unsigned(x_out));
        check_field("y_out", want.y, $unsigned(y_out));
        check_field("z_out", want.z, $unsigned(z_out));
        check_field("finite_total", want.finite, finite_total);
        check_field("kept_total", want.kept, kept_total);
        check_field("rejected_total", want.rejected, rejected_total);
        check_field("scan_done", want.done, scan_done);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("rigid_transform_crop_filter_core test failed");
      $finish;
    end
  end

  // Result sink: stall pattern of its own, plus one long hold-off
  initial begin
    sink_mode_t  mode;
    int unsigned left;
    logic        held;
    out_ready = 1'b0;
    mode      = SINK_OPEN;
    left      = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && points_accepted >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 200);
      end
      left--;
      case (mode)
        SINK_OPEN:    out_ready <= 1'b1;
        SINK_RANDOM:  out_ready <= $urandom_range(0, 1);
        SINK_PATTERN: out_ready <= (left % 4) != 0;
        default:      out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    cfg_t    reset_cfg, phase_cfg;
    cfg_t    dir_cfg[4];
    point_t  p;
    result_t typed_res;
    logic [1:0] cur_phase;

    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    x_coord     = '0;
    y_coord     = '0;
    z_coord     = '0;
    point_valid = 1'b0;
    scan_last   = 1'b0;
    typed_res   = '0;
    finite_cnt  = '0;
    kept_cnt    = '0;

    reset_cfg.rot_row_x    = 48'd16384;
    reset_cfg.rot_row_y    = 48'd1073741824;
    reset_cfg.offset_x     = '0;
    reset_cfg.offset_y     = '0;
    reset_cfg.legal_x_low  = COORD_MIN;
    reset_cfg.legal_x_high = COORD_MAX;
    reset_cfg.legal_y_low  = COORD_MIN;
    reset_cfg.legal_y_high = COORD_MAX;
    arena_cfg  = reset_cfg;
    dir_cfg[0] = reset_cfg;

    // Tight box around the origin, identity rotation
    dir_cfg[1] = reset_cfg;
    dir_cfg[1].rot_row_x    = {16'd0, 16'd0, COEF_P1};
    dir_cfg[1].legal_x_low  = -ONE_M;
    dir_cfg[1].legal_x_high = ONE_M;
    dir_cfg[1].legal_y_low  = -2 * ONE_M;
    dir_cfg[1].legal_y_high = 2 * ONE_M;

    // Inverted x bounds: nothing may pass
    dir_cfg[2] = reset_cfg;
    dir_cfg[2].legal_x_low  = ONE_M;
    dir_cfg[2].legal_x_high = -ONE_M;

    // Extreme coefficients with z weight and extreme offsets
    dir_cfg[3].rot_row_x    = {COEF_MIN, COEF_MAX, COEF_M1};
    dir_cfg[3].rot_row_y    = {COEF_MAX, COEF_MIN, COEF_P1};
    dir_cfg[3].offset_x     = COORD_MAX;
    dir_cfg[3].offset_y     = COORD_MIN;
    dir_cfg[3].legal_x_low  = '0;
    dir_cfg[3].legal_x_high = COORD_MAX;
    dir_cfg[3].legal_y_low  = COORD_MIN;
    dir_cfg[3].legal_y_high = '0;

    // Reset settings: identity and full box, so every valid point is kept
    add_row(0, '0, '0, '0, 1, 0, 1, 1, 1, 1);
    add_row(0, COORD_MAX, COORD_MAX, COORD_MAX, 1, 0, 1, 1, 2, 2);
    add_row(0, COORD_MIN, COORD_MIN, COORD_MIN, 1, 0, 1, 1, 3, 3);
    add_row(0, COORD_MIN, COORD_MAX, '0, 0, 0, 1, 0, 3, 3);
    add_row(0, '1, 32'd1, '1, 1, 1, 1, 1, 4, 4);
    add_row(0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 1, 1, 0, 0, 0);
    // Inclusive edges and one step outside each
    add_row(1, ONE_M, -2 * ONE_M, COORD_MAX, 1, 0, 1, 1, 1, 1);
    add_row(1, -ONE_M, 2 * ONE_M, COORD_MIN, 1, 0, 1, 1, 2, 2);
    add_row(1, ONE_M + 1, '0, '0, 1, 0, 1, 0, 3, 2);
    add_row(1, '0, -2 * ONE_M - 1, '0, 1, 0, 1, 0, 4, 2);
    add_row(1, -ONE_M - 1, '0, '0, 1, 0, 1, 0, 5, 2);
    add_row(1, '0, '0, '0, 0, 0, 1, 0, 5, 2);
    add_row(1, '0, 2 * ONE_M + 1, '0, 1, 1, 1, 0, 6, 2);
    add_row(2, '0, '0, '0, 1, 0, 1, 0, 1, 0);
    add_row(2, ONE_M, '0, '0, 1, 1, 1, 0, 2, 0);
    add_row(3, COORD_MAX, COORD_MAX, COORD_MAX, 1, 0, 0, 0, 0, 0);
    add_row(3, COORD_MIN, COORD_MIN, COORD_MIN, 1, 0, 0, 0, 0, 0);
    add_row(3, COORD_MAX, COORD_MIN, '0, 1, 0, 0, 0, 0, 0);
    add_row(3, COORD_MIN, COORD_MAX, COORD_MAX, 1, 0, 0, 0, 0, 0);
    add_row(3, '0, '0, '0, 1, 0, 0, 0, 0, 0);
    add_row(3, ONE_M, -2 * ONE_M, 3 * ONE_M, 1, 1, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values must read back before any write
    apply_cfg(reset_cfg, 1'b0);

    // Directed table
    cur_phase = 2'd0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].phase != cur_phase) begin
        stop_points();
        drain_results();
        cur_phase = dir_rows[i].phase;
        apply_cfg(dir_cfg[cur_phase], 1'b1);
      end
      typed_res.keep     = dir_rows[i].keep;
      typed_res.x        = dir_rows[i].pt.x;
      typed_res.y        = dir_rows[i].pt.y;
      typed_res.z        = dir_rows[i].pt.z;
      typed_res.finite   = dir_rows[i].finite;
      typed_res.kept     = dir_rows[i].kept;
      typed_res.rejected = dir_rows[i].finite - dir_rows[i].kept;
      typed_res.done     = dir_rows[i].pt.last;
      send_point(dir_rows[i].pt, dir_rows[i].typed, typed_res);
    end

    // Random phases, each under fresh settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      stop_points();
      drain_results();
      rand_cfg(ph, phase_cfg);
      apply_cfg(phase_cfg, 1'b1);
      repeat (POINTS_PER_PHASE) begin
        rand_point(p);
        send_point(p, 1'b0, typed_res);
      end
    end

    stop_points();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("rigid_transform_crop_filter_core test passed");
    end else begin
      $display("rigid_transform_crop_filter_core test failed");
    end
    $finish;
  end

endmodule
